### rtl/core/nv12_chroma_upsample_unshuffle_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chroma upsample / unshuffle block
// ----------------------------------------------------------------------------
`ifndef NV12_CHROMA_UPSAMPLE_UNSHUFFLE_TOP_ASSERT_SVH
`define NV12_CHROMA_UPSAMPLE_UNSHUFFLE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NVCU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nvcu assertion failed");

// Next-cycle implication, checked out of reset.
`define NVCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nvcu assertion failed");

`endif

### rtl/core/nvcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvcu_pkg
// Shared types, constants and the chroma upsample function.
// ----------------------------------------------------------------------------
package nvcu_pkg;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_CORE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CORE_HEIGHT = CFG_IDX_W'(1);

    // One core element: four luma bytes, then U, then V.
    typedef struct packed {
        logic [7:0]  v;
        logic [7:0]  u;
        logic [31:0] luma;
    } t_item;

    // Position of the element that is loaded into the emit stage.
    typedef struct packed {
        logic has_up;   // a row above exists
        logic col_nz;   // a column to the left exists
        logic right;    // right edge column
        logic bottom;   // bottom row
    } t_pos_flags;

    // Which neighbor element a result stands for.
    typedef enum logic [1:0] {
        RES_UPPER_LEFT  = 2'd0,
        RES_UPPER_RIGHT = 2'd1,
        RES_LOWER_LEFT  = 2'd2,
        RES_LOWER_RIGHT = 2'd3
    } t_res_kind;

    function automatic logic [31:0] upsample_quad(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] c,
        input logic [7:0] d
    );
        logic [8:0] s_ab;
        logic [8:0] s_ac;
        logic [9:0] s_all;
        s_ab  = {1'b0, a} + {1'b0, b} + 9'd1;
        s_ac  = {1'b0, a} + {1'b0, c} + 9'd1;
        s_all = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d} + 10'd2;
        return {s_all[9:2], s_ac[8:1], s_ab[8:1], a};
    endfunction

endpackage

### rtl/core/nvcu_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvcu_line_buf
// One-row element store; read old and write new in the same cycle.
// ----------------------------------------------------------------------------
module nvcu_line_buf
    import nvcu_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_addr,
    input  t_item         i_wdata,
    output t_item         o_rdata
);

    t_item r_mem [DEPTH];
    t_item r_rdata;

    // Read-first: the element of the row above comes out, this one goes in.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/nvcu_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvcu_emit
// Holds one element, sequences its results and drives the output register.
// ----------------------------------------------------------------------------
module nvcu_emit
    import nvcu_pkg::*;
#(
    parameter int IDX_W = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_item            i_cur,
    input  t_item            i_upper,
    input  t_pos_flags       i_flags,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [IDX_W-1:0] i_idx_up,
    input  logic             i_out_stall,
    output logic             o_free,
    output logic             o_out_valid,
    output logic [IDX_W-1:0] o_element_index,
    output logic [31:0]      o_luma_quad,
    output logic [31:0]      o_u_quad,
    output logic [31:0]      o_v_quad,
    output logic             o_last_of_run
);

    t_item            r_cur;
    t_item            r_prev;
    t_item            r_held;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_idx_up;
    logic [3:0]       r_pend;
    logic [3:0]       n_pend;
    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_idx;
    logic [31:0]      r_o_luma;
    logic [31:0]      r_o_u;
    logic [31:0]      r_o_v;
    logic             r_o_last;

    t_res_kind        sel_kind;
    logic [3:0]       sel_mask;
    logic [3:0]       rest;
    logic             out_load;
    t_item            nb_a;
    t_item            nb_b;
    t_item            nb_c;
    t_item            nb_d;
    logic [IDX_W-1:0] sel_idx;
    logic [3:0]       new_pend;

    assign new_pend = {i_flags.bottom & i_flags.right,
                       i_flags.bottom & i_flags.col_nz,
                       i_flags.has_up & i_flags.right,
                       i_flags.has_up & i_flags.col_nz};

    // Lowest pending result first: raster order.
    always_comb begin
        if (r_pend[0]) begin
            sel_kind = RES_UPPER_LEFT;
        end else if (r_pend[1]) begin
            sel_kind = RES_UPPER_RIGHT;
        end else if (r_pend[2]) begin
            sel_kind = RES_LOWER_LEFT;
        end else begin
            sel_kind = RES_LOWER_RIGHT;
        end
    end

    assign sel_mask = 4'b0001 << sel_kind;
    assign rest     = r_pend & ~sel_mask;
    assign out_load = (r_pend != 4'b0000) && (!r_o_valid || !i_out_stall);
    assign o_free   = (r_pend == 4'b0000) || (out_load && (rest == 4'b0000));

    always_comb begin
        case (sel_kind)
            RES_UPPER_LEFT: begin
                nb_a    = r_held;
                nb_b    = i_upper;
                nb_c    = r_prev;
                nb_d    = r_cur;
                sel_idx = r_idx_up - IDX_W'(1);
            end
            RES_UPPER_RIGHT: begin
                nb_a    = i_upper;
                nb_b    = i_upper;
                nb_c    = r_cur;
                nb_d    = r_cur;
                sel_idx = r_idx_up;
            end
            RES_LOWER_LEFT: begin
                nb_a    = r_prev;
                nb_b    = r_cur;
                nb_c    = r_prev;
                nb_d    = r_cur;
                sel_idx = r_idx - IDX_W'(1);
            end
            default: begin
                nb_a    = r_cur;
                nb_b    = r_cur;
                nb_c    = r_cur;
                nb_d    = r_cur;
                sel_idx = r_idx;
            end
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        if (i_load) begin
            n_pend = new_pend;
        end else if (out_load) begin
            n_pend = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 4'b0000;
            r_o_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Shift the neighbor context along with each new element; load each selected result into the output register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_held   <= i_upper;
            r_prev   <= r_cur;
            r_cur    <= i_cur;
            r_idx    <= i_idx;
            r_idx_up <= i_idx_up;
        end
        if (out_load) begin
            r_o_idx  <= sel_idx;
            r_o_luma <= nb_a.luma;
            r_o_u    <= upsample_quad(nb_a.u, nb_b.u, nb_c.u, nb_d.u);
            r_o_v    <= upsample_quad(nb_a.v, nb_b.v, nb_c.v, nb_d.v);
            r_o_last <= (rest == 4'b0000);
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_element_index = r_o_idx;
    assign o_luma_quad     = r_o_luma;
    assign o_u_quad        = r_o_u;
    assign o_v_quad        = r_o_v;
    assign o_last_of_run   = r_o_last;

endmodule

### rtl/core/nv12_chroma_upsample_unshuffle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv12_chroma_upsample_unshuffle_top
// NV12 to YUV444 chroma upsampler with 2x2 luma unshuffle, streaming.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one request per core element, a
//   2x2 luma block plus its co-sited U and V, in raster order over the grid.
//   Output channel (o_out_valid / i_out_stall): one request per finished
//   element with its index, the four luma bytes and four upsampled U and V.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets the
//   core width, index 1 the core height; both restart the frame. Write only
//   while idle. Out-of-range values clamp to 1 and to the maximum.
// Timing:
//   An element is emitted once its right and lower neighbors arrived, so
//   results trail by about one row. A result passes from the request that
//   completes it through the pending flags, then the output register. Inner
//   requests cause one result, most first-row and first-column ones none;
//   right-edge and bottom-row ones two, the corner four. Throughput is one
//   request per cycle unless the output stalls, set by the single output
//   register; a request with several results holds input until all are loaded.
// Reset clears counters, pending results and the output valid; row store
// contents stay undefined and are only used after being written. While the
// receiver stalls, the output register holds and the input stalls as soon as
// an element with results waits behind it.
// ----------------------------------------------------------------------------
module nv12_chroma_upsample_unshuffle_top
    import nvcu_pkg::*;
#(
    parameter int MAX_CORE_WIDTH  = 1024,
    parameter int MAX_CORE_HEIGHT = 4096,
    localparam int CW    = $clog2(MAX_CORE_WIDTH),
    localparam int RW    = $clog2(MAX_CORE_HEIGHT),
    localparam int IDX_W = CW + RW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input requests
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_luma_top_left,
    input  logic [7:0]            i_luma_top_right,
    input  logic [7:0]            i_luma_bottom_left,
    input  logic [7:0]            i_luma_bottom_right,
    input  logic [7:0]            i_chroma_u,
    input  logic [7:0]            i_chroma_v,
    // output requests
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [IDX_W-1:0]      o_element_index,
    output logic [31:0]           o_luma_quad,
    output logic [31:0]           o_u_quad,
    output logic [31:0]           o_v_quad,
    output logic                  o_last_of_run,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WW = CW + 1;
    localparam int HW = RW + 1;

    // Effective (clamped) grid size.
    logic [WW-1:0]    r_w;
    logic [HW-1:0]    r_h;
    logic [WW-1:0]    n_w;
    logic [HW-1:0]    n_h;
    // Position of the next request and its linear index.
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [IDX_W-1:0] r_idx;

    logic             free;
    logic             accept;
    logic             cfg_wr;
    logic             col_last;
    logic             row_last;
    logic [WIDTH_REG_W-1:0]  cfg_w_raw;
    logic [HEIGHT_REG_W-1:0] cfg_h_raw;
    t_item            cur;
    t_item            upper;
    t_pos_flags       flags;
    logic [IDX_W-1:0] idx_up;

    assign accept      = i_in_valid && free;
    assign o_in_stall  = !free;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    assign cur.luma = {i_luma_bottom_right, i_luma_bottom_left,
                       i_luma_top_right, i_luma_top_left};
    assign cur.u    = i_chroma_u;
    assign cur.v    = i_chroma_v;

    assign col_last = ({1'b0, r_col} == (r_w - WW'(1)));
    assign row_last = ({1'b0, r_row} == (r_h - HW'(1)));

    assign flags.has_up = (r_row != '0);
    assign flags.col_nz = (r_col != '0);
    assign flags.right  = col_last;
    assign flags.bottom = row_last;

    // Index of the element above; only used when a row above exists.
    assign idx_up = r_idx - IDX_W'(r_w);

    // Clamp register values into the supported range.
    always_comb begin
        cfg_w_raw = i_cfg_data[WIDTH_REG_W-1:0];
        cfg_h_raw = i_cfg_data[HEIGHT_REG_W-1:0];
        if (cfg_w_raw == '0) begin
            n_w = WW'(1);
        end else if (int'(cfg_w_raw) > MAX_CORE_WIDTH) begin
            n_w = WW'(MAX_CORE_WIDTH);
        end else begin
            n_w = WW'(cfg_w_raw);
        end
        if (cfg_h_raw == '0) begin
            n_h = HW'(1);
        end else if (int'(cfg_h_raw) > MAX_CORE_HEIGHT) begin
            n_h = HW'(MAX_CORE_HEIGHT);
        end else begin
            n_h = HW'(cfg_h_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= WW'(1);
            r_h   <= HW'(1);
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (cfg_wr && (i_cfg_index == REG_CORE_WIDTH)) begin
            // restart the frame
            r_w   <= n_w;
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (cfg_wr && (i_cfg_index == REG_CORE_HEIGHT)) begin
            r_h   <= n_h;
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (accept) begin
            // advance in raster order, wrap at the frame end
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row <= '0;
                    r_idx <= '0;
                end else begin
                    r_row <= r_row + RW'(1);
                    r_idx <= r_idx + IDX_W'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Row store: read the element above, write this one, same address.
    nvcu_line_buf #(
        .DEPTH (MAX_CORE_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (r_col),
        .i_wdata (cur),
        .o_rdata (upper)
    );

    nvcu_emit #(
        .IDX_W (IDX_W)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_cur           (cur),
        .i_upper         (upper),
        .i_flags         (flags),
        .i_idx           (r_idx),
        .i_idx_up        (idx_up),
        .i_out_stall     (i_out_stall),
        .o_free          (free),
        .o_out_valid     (o_out_valid),
        .o_element_index (o_element_index),
        .o_luma_quad     (o_luma_quad),
        .o_u_quad        (o_u_quad),
        .o_v_quad        (o_v_quad),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

### rtl/core/nvcu_top_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvcu_top_checker
// Port-level checks of the chroma upsample / unshuffle block.
// ----------------------------------------------------------------------------
`include "nv12_chroma_upsample_unshuffle_top_assert.svh"

module nvcu_top_checker #(
    parameter int IDX_W = 22
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [IDX_W-1:0] o_element_index,
    input logic [31:0]      o_luma_quad,
    input logic [31:0]      o_u_quad,
    input logic [31:0]      o_v_quad,
    input logic             o_last_of_run
);

    // A stalled result holds.
    `NVCU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_element_index) && $stable(o_luma_quad) && $stable(o_u_quad) && $stable(o_v_quad) && $stable(o_last_of_run))

    // Results of one request follow back to back.
    `NVCU_ASSERT_NEXT(a_run_contiguous, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last_of_run, o_out_valid)

    // Nothing is presented in the first cycle out of reset.
    `NVCU_ASSERT_IMPLY(a_reset_clear, i_clk, i_rst_n, $rose(i_rst_n), !o_out_valid)

endmodule

bind nv12_chroma_upsample_unshuffle_top nvcu_top_checker #(
    .IDX_W (IDX_W)
) u_nvcu_top_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_element_index (o_element_index),
    .o_luma_quad     (o_luma_quad),
    .o_u_quad        (o_u_quad),
    .o_v_quad        (o_v_quad),
    .o_last_of_run   (o_last_of_run)
);
